// File: rtl/ritoa_pkg.sv
package ritoa_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MAX_DIGITS = 32;

  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned DIGIT_W    = 6;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned WORK_W     = DIV_CYCLES * DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam logic [WORK_W-1:0]    VALUE_MASK  = WORK_W'({VALUE_BITS{1'b1}});
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(DIV_CYCLES - 1);
  localparam logic [CNT_W-1:0]     COUNT_LAST  = CNT_W'(MAX_DIGITS - 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_A  = 7'd97;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } state_e;

  typedef struct packed {
    logic load;
    logic div;
    logic rd;
    logic next;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic conv_end;
    logic idx_zero;
  } status_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DECIMAL_LIMIT) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_LOWER_A + CHAR_W'(d - DECIMAL_LIMIT);
    end
    return res;
  endfunction

endpackage

// File: rtl/ritoa_if.sv
interface ritoa_in_if;
  logic                                valid;
  logic                                ready;
  logic [ritoa_pkg::IN_VALUE_W-1:0]    value;
  logic [ritoa_pkg::RADIX_W-1:0]       radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface ritoa_out_if;
  logic                                valid;
  logic                                ready;
  logic [ritoa_pkg::CHAR_W-1:0]        digit_char;
  logic                                last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: rtl/radix_integer_to_ascii.sv
// Channel   Direction  Payload                     Handshake
// in_i      sink       value[31:0], radix[5:0]     valid / ready
// out_o     source     digit_char[6:0], last_digit valid / ready
//
// Each digit is a long division of the whole working word in the shared divider,
// which resolves eight quotient bits a cycle.
// Each character is then read from the digit store, then output.
// An item yields at most 32 digits, and output stalls hold it up.
// Reset clears the controller and counters; the digit store is not cleared.
// A stalled output holds its character; no new item is taken until the last one goes.
module radix_integer_to_ascii (
  input  logic       clk_i,
  input  logic       rst_ni,
  ritoa_in_if.sink   in_i,
  ritoa_out_if.source out_o
);

  ritoa_pkg::cmd_t    cmd;
  ritoa_pkg::status_t status;

  ritoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ritoa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (in_i.value),
    .radix_i      (in_i.radix),
    .digit_char_o (out_o.digit_char),
    .last_digit_o (out_o.last_digit)
  );

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("output valid while input ready");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready straight after a transaction");

  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_digit) |=> in_i.ready)
    else $error("not idle after final character");

endmodule

// File: rtl/ritoa_ctrl.sv
module ritoa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ritoa_pkg::status_t  status_i,
  output ritoa_pkg::cmd_t     cmd_o
);

  ritoa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ritoa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ritoa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ritoa_pkg::ST_DIV;
        end
      end
      ritoa_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        if (status_i.div_last && status_i.conv_end) begin
          state_d = ritoa_pkg::ST_READ;
        end
      end
      ritoa_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ritoa_pkg::ST_SHOW;
      end
      ritoa_pkg::ST_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.idx_zero) begin
            state_d = ritoa_pkg::ST_IDLE;
          end else begin
            cmd_o.next = 1'b1;
            state_d    = ritoa_pkg::ST_READ;
          end
        end
      end
      default: state_d = ritoa_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/ritoa_dp.sv
module ritoa_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ritoa_pkg::cmd_t                   cmd_i,
  output ritoa_pkg::status_t                status_o,
  input  logic [ritoa_pkg::IN_VALUE_W-1:0]  value_i,
  input  logic [ritoa_pkg::RADIX_W-1:0]     radix_i,
  output logic [ritoa_pkg::CHAR_W-1:0]      digit_char_o,
  output logic                              last_digit_o
);

  logic [ritoa_pkg::WORK_W-1:0]    work_q;
  logic [ritoa_pkg::WORK_W-1:0]    work_next;
  logic [ritoa_pkg::WORK_W-1:0]    work_load;
  logic [ritoa_pkg::IN_VALUE_W+ritoa_pkg::WORK_W-1:0] value_ext;
  logic [ritoa_pkg::DIGIT_W-1:0]   rem_q;
  logic [ritoa_pkg::DIGIT_W-1:0]   rem_next;
  logic [ritoa_pkg::RADIX_W-1:0]   radix_q;
  logic [ritoa_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [ritoa_pkg::CNT_W-1:0]     n_q;
  logic [ritoa_pkg::IDX_W-1:0]     idx_q;
  logic [ritoa_pkg::DIGIT_W-1:0]   rd_q;
  logic [ritoa_pkg::DIV_STEPS-1:0] quot_bits;
  logic                            div_last;

  logic [ritoa_pkg::DIGIT_W-1:0]   digit_mem [ritoa_pkg::MAX_DIGITS];

  assign value_ext = {{ritoa_pkg::WORK_W{1'b0}}, value_i};
  assign work_load = value_ext[ritoa_pkg::WORK_W-1:0] & ritoa_pkg::VALUE_MASK;

  // long division of the top bits of the word by the radix, one bit per step
  always_comb begin
    logic [ritoa_pkg::DIGIT_W:0]     part;
    logic [ritoa_pkg::DIV_STEPS-1:0] top;
    logic [ritoa_pkg::DIGIT_W-1:0]   rem;
    top       = work_q[ritoa_pkg::WORK_W-1 -: ritoa_pkg::DIV_STEPS];
    rem       = rem_q;
    quot_bits = '0;
    for (int i = ritoa_pkg::DIV_STEPS - 1; i >= 0; i--) begin
      part = {rem, top[i]};
      if (part >= {1'b0, radix_q}) begin
        part         = part - {1'b0, radix_q};
        quot_bits[i] = 1'b1;
      end
      rem = part[ritoa_pkg::DIGIT_W-1:0];
    end
    rem_next  = rem;
    work_next = (work_q << ritoa_pkg::DIV_STEPS) | ritoa_pkg::WORK_W'(quot_bits);
  end

  assign div_last          = (cnt_q == ritoa_pkg::DIV_LAST);
  assign status_o.div_last = div_last;
  assign status_o.conv_end = (work_next == '0) || (n_q == ritoa_pkg::COUNT_LAST);
  assign status_o.idx_zero = (idx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      n_q   <= '0;
      idx_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      n_q   <= '0;
    end else if (cmd_i.div) begin
      if (div_last) begin
        cnt_q <= '0;
        n_q   <= n_q + 1'b1;
        idx_q <= n_q[ritoa_pkg::IDX_W-1:0];
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else if (cmd_i.next) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q  <= work_load;
      rem_q   <= '0;
      radix_q <= ritoa_pkg::clamp_radix(radix_i);
    end else if (cmd_i.div) begin
      work_q <= work_next;
      // restart the remainder for the next digit
      rem_q  <= div_last ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div && div_last) begin
      digit_mem[n_q[ritoa_pkg::IDX_W-1:0]] <= rem_next;
    end
    if (cmd_i.rd) begin
      rd_q <= digit_mem[idx_q];
    end
  end

  assign digit_char_o = ritoa_pkg::digit_to_ascii(rd_q);
  assign last_digit_o = (idx_q == '0);

endmodule
